// ===== src/swmv_pkg.sv =====
package swmv_pkg;

    localparam int NUM_CLASSES_DEF = 16;
    localparam int MAX_WINDOW_DEF  = 64;

    localparam int LABEL_W   = 8;
    localparam int WIN_W     = 7;
    localparam int VOTE_W    = 7;
    localparam int WIN_RESET = 16;

    typedef logic [WIN_W-1:0] cnt_t;

    // control from the sequencer to the compare unit
    typedef struct packed {
        logic clear;
        logic update;
    } scan_ctl_t;

    function automatic int addr_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

// ===== src/swmv_ram.sv =====
module swmv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [swmv_pkg::addr_w(DEPTH)-1:0]    waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [swmv_pkg::addr_w(DEPTH)-1:0]    raddr,
    output logic [WIDTH-1:0]                      rdata
);
    import swmv_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/swmv_scan.sv =====
module swmv_scan #(
    parameter int NUM_CLASSES = swmv_pkg::NUM_CLASSES_DEF
) (
    input  logic                                        clk,
    input  swmv_pkg::scan_ctl_t                         ctl,
    input  logic [swmv_pkg::addr_w(NUM_CLASSES)-1:0]    idx,
    input  swmv_pkg::cnt_t                              count,
    output logic [swmv_pkg::addr_w(NUM_CLASSES)-1:0]    best
);
    import swmv_pkg::*;

    localparam int CW = addr_w(NUM_CLASSES);

    logic [CW-1:0] best_reg;
    logic [CW-1:0] best_next;
    cnt_t          best_cnt_reg;
    cnt_t          best_cnt_next;

    // strict greater keeps the lowest class on ties
    always_comb
    begin
        best_next     = best_reg;
        best_cnt_next = best_cnt_reg;
        if (ctl.clear)
        begin
            best_next     = '0;
            best_cnt_next = '0;
        end
        else if (ctl.update && (count > best_cnt_reg))
        begin
            best_next     = idx;
            best_cnt_next = count;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg     <= best_next;
        best_cnt_reg <= best_cnt_next;
    end

    assign best = best_reg;

endmodule

// ===== src/sliding_window_majority_vote_core.sv =====
// channel  | signals                          | direction
// input    | in_valid, in_stall, class_label  | label word in
// output   | out_valid, out_stall, voted_class, bad_label | vote word out
// config   | cfg_wr_en, cfg_wr_data           | window length write
//
// A valid label with the window full first retires the oldest label; an
// out-of-range label goes straight to the output step. The count scan
// reads one counter per cycle from the count RAM, lowest class first.
// in_stall is high from acceptance until the result is loaded into the
// output register; a held output word stalls the sequencer in its last step.
// Reset clears counts via valid bits; the label ring needs no clearing.
module sliding_window_majority_vote_core #(
    parameter int NUM_CLASSES = swmv_pkg::NUM_CLASSES_DEF,
    parameter int MAX_WINDOW  = swmv_pkg::MAX_WINDOW_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [swmv_pkg::LABEL_W-1:0]  class_label,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [swmv_pkg::VOTE_W-1:0]   voted_class,
    output logic                          bad_label,
    input  logic                          cfg_wr_en,
    input  logic [swmv_pkg::WIN_W-1:0]    cfg_wr_data
);
    import swmv_pkg::*;

    localparam int CW      = addr_w(NUM_CLASSES);
    localparam int RAW     = addr_w(MAX_WINDOW);
    localparam int SUM_W   = ((RAW > WIN_W) ? RAW : WIN_W) + 1;
    localparam int WIN_MAX = (MAX_WINDOW > 127) ? 127 : MAX_WINDOW;
    localparam int WIN_RST = (WIN_RESET > WIN_MAX) ? WIN_MAX : WIN_RESET;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_EV_RD  = 4'd1;
    localparam logic [3:0] S_EV_CNT = 4'd2;
    localparam logic [3:0] S_EV_WR  = 4'd3;
    localparam logic [3:0] S_ADD    = 4'd4;
    localparam logic [3:0] S_ADD_WR = 4'd5;
    localparam logic [3:0] S_SCAN   = 4'd6;
    localparam logic [3:0] S_DRAIN  = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    logic [3:0]             state_reg, state_next;
    logic [WIN_W-1:0]       win_reg, win_next;
    logic [WIN_W-1:0]       fill_reg, fill_next;
    logic [RAW-1:0]         head_reg, head_next;
    logic [NUM_CLASSES-1:0] cnt_vld_reg, cnt_vld_next;
    logic                   cnt_rvld_reg;
    logic [CW-1:0]          idx_reg, idx_next;
    logic [CW-1:0]          old_reg, old_next;
    logic                   bad_reg, bad_next;
    logic [CW-1:0]          scan_idx_reg, scan_idx_next;
    logic [CW-1:0]          pidx_reg, pidx_next;
    logic                   scan_pend_reg, scan_pend_next;
    logic                   out_valid_reg, out_valid_next;
    logic [VOTE_W-1:0]      voted_reg, voted_next;
    logic                   obad_reg, obad_next;

    logic                   ring_we;
    logic [RAW-1:0]         ring_waddr;
    logic [RAW-1:0]         ring_raddr;
    logic [CW-1:0]          ring_rdata;
    logic                   cnt_we;
    logic [CW-1:0]          cnt_waddr;
    cnt_t                   cnt_wdata;
    logic [CW-1:0]          cnt_raddr;
    cnt_t                   cnt_rdata;
    cnt_t                   cnt_eff;
    scan_ctl_t              scan_ctl;
    logic [CW-1:0]          best;

    logic                   in_acc;
    logic                   label_ok;
    logic [SUM_W-1:0]       tail_sum;
    logic [WIN_W-1:0]       win_clamped;

    assign in_acc   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign label_ok = (class_label != '0) && (class_label <= LABEL_W'(NUM_CLASSES));
    assign cnt_eff  = cnt_rvld_reg ? cnt_rdata : '0;

    assign tail_sum = SUM_W'(head_reg) + SUM_W'(fill_reg);
    assign ring_waddr = (tail_sum >= SUM_W'(MAX_WINDOW))
                        ? RAW'(tail_sum - SUM_W'(MAX_WINDOW)) : RAW'(tail_sum);
    assign ring_raddr = head_reg;
    assign win_clamped = (cfg_wr_data > WIN_W'(WIN_MAX)) ? WIN_W'(WIN_MAX) : cfg_wr_data;

    always_comb
    begin
        state_next     = state_reg;
        win_next       = win_reg;
        fill_next      = fill_reg;
        head_next      = head_reg;
        cnt_vld_next   = cnt_vld_reg;
        idx_next       = idx_reg;
        old_next       = old_reg;
        bad_next       = bad_reg;
        scan_idx_next  = scan_idx_reg;
        pidx_next      = pidx_reg;
        scan_pend_next = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        voted_next     = voted_reg;
        obad_next      = obad_reg;
        ring_we        = 1'b0;
        cnt_we         = 1'b0;
        cnt_waddr      = idx_reg;
        cnt_wdata      = cnt_eff + cnt_t'(1);
        cnt_raddr      = idx_reg;
        scan_ctl       = '{clear: 1'b0, update: scan_pend_reg};

        if (cfg_wr_en && (cfg_wr_data != '0))
        begin
            win_next     = win_clamped;
            fill_next    = '0;
            head_next    = '0;
            cnt_vld_next = '0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    idx_next = CW'(class_label - LABEL_W'(1));
                    bad_next = !label_ok;
                    if (!label_ok)
                        state_next = S_OUT;
                    else if (fill_reg >= win_reg)
                        state_next = S_EV_RD;
                    else
                        state_next = S_ADD;
                end
            end
            S_EV_RD:
            begin
                state_next = S_EV_CNT;
            end
            S_EV_CNT:
            begin
                cnt_raddr  = ring_rdata;
                old_next   = ring_rdata;
                state_next = S_EV_WR;
            end
            S_EV_WR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = old_reg;
                cnt_wdata = (cnt_eff == '0) ? '0 : cnt_eff - cnt_t'(1);
                cnt_vld_next[old_reg] = 1'b1;
                head_next = (head_reg == RAW'(MAX_WINDOW - 1)) ? '0 : head_reg + RAW'(1);
                fill_next = fill_reg - WIN_W'(1);
                state_next = S_ADD;
            end
            S_ADD:
            begin
                ring_we    = 1'b1;
                state_next = S_ADD_WR;
            end
            S_ADD_WR:
            begin
                cnt_we = 1'b1;
                cnt_vld_next[idx_reg] = 1'b1;
                fill_next      = fill_reg + WIN_W'(1);
                scan_ctl.clear = 1'b1;
                scan_idx_next  = '0;
                state_next     = S_SCAN;
            end
            S_SCAN:
            begin
                cnt_raddr      = scan_idx_reg;
                scan_pend_next = 1'b1;
                pidx_next      = scan_idx_reg;
                if (scan_idx_reg == CW'(NUM_CLASSES - 1))
                    state_next = S_DRAIN;
                else
                    scan_idx_next = scan_idx_reg + CW'(1);
            end
            S_DRAIN:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    obad_next      = bad_reg;
                    voted_next     = bad_reg ? '0 : VOTE_W'(best) + VOTE_W'(1);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            win_reg       <= WIN_W'(WIN_RST);
            fill_reg      <= '0;
            head_reg      <= '0;
            cnt_vld_reg   <= '0;
            scan_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            win_reg       <= win_next;
            fill_reg      <= fill_next;
            head_reg      <= head_next;
            cnt_vld_reg   <= cnt_vld_next;
            scan_pend_reg <= scan_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        old_reg      <= old_next;
        bad_reg      <= bad_next;
        scan_idx_reg <= scan_idx_next;
        pidx_reg     <= pidx_next;
        voted_reg    <= voted_next;
        obad_reg     <= obad_next;
        // valid flag follows the count RAM read
        cnt_rvld_reg <= cnt_vld_reg[cnt_raddr];
    end

    swmv_ram #(
        .WIDTH (CW),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (idx_reg),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    swmv_ram #(
        .WIDTH (WIN_W),
        .DEPTH (NUM_CLASSES)
    ) u_counts (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    swmv_scan #(
        .NUM_CLASSES (NUM_CLASSES)
    ) u_scan (
        .clk   (clk),
        .ctl   (scan_ctl),
        .idx   (pidx_reg),
        .count (cnt_eff),
        .best  (best)
    );

    assign out_valid   = out_valid_reg;
    assign voted_class = voted_reg;
    assign bad_label   = obad_reg;

endmodule

// ===== src/swmv_checker.sv =====
module swmv_checker #(
    parameter int NUM_CLASSES = swmv_pkg::NUM_CLASSES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [swmv_pkg::VOTE_W-1:0]   voted_class,
    input  logic                          bad_label
);
    import swmv_pkg::*;

    // a flagged word never carries a class
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_label |-> voted_class == '0)
        else $error("bad label word with nonzero class");

    a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !bad_label |->
            (voted_class != '0) && (voted_class <= VOTE_W'(NUM_CLASSES)))
        else $error("voted class out of range");

    // one word in flight: busy right after acceptance
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second word accepted while busy");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=>
            out_valid && $stable(voted_class) && $stable(bad_label))
        else $error("stalled output word changed");

endmodule

bind sliding_window_majority_vote_core swmv_checker #(
    .NUM_CLASSES (NUM_CLASSES)
) u_swmv_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .voted_class (voted_class),
    .bad_label   (bad_label)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import swmv_pkg::*;

    localparam int NUM_CLASSES = NUM_CLASSES_DEF;
    localparam int MAX_WINDOW  = MAX_WINDOW_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 2 * (NUM_CLASSES + 7);

    typedef struct packed {
        logic [VOTE_W-1:0] voted;
        logic              bad;
    } vote_word_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [LABEL_W-1:0] class_label;
    logic               out_valid;
    logic               out_stall;
    logic [VOTE_W-1:0]  voted_class;
    logic               bad_label;
    logic               cfg_wr_en;
    logic [WIN_W-1:0]   cfg_wr_data;

    // predictor state
    logic [3:0]         label_hist [MAX_WINDOW];
    cnt_t               class_tally [NUM_CLASSES];
    logic [6:0]         hist_fill;
    logic [5:0]         hist_head;
    cnt_t               win_len;

    vote_word_t         pending_votes [$];

    int                 src_idle_pct;
    int                 dst_idle_pct;
    int                 hot_base;
    int                 errors;
    int                 labels_sent;
    int                 bad_sent;
    int                 votes_checked;
    int                 window_writes;
    int                 quiet_cycles;

    sliding_window_majority_vote_core #(
        .NUM_CLASSES (NUM_CLASSES),
        .MAX_WINDOW  (MAX_WINDOW)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .class_label (class_label),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .voted_class (voted_class),
        .bad_label   (bad_label),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void clear_history();
        for (int i = 0; i < NUM_CLASSES; i++)
            class_tally[i] = '0;
        for (int i = 0; i < MAX_WINDOW; i++)
            label_hist[i] = '0;
        hist_fill = '0;
        hist_head = '0;
    endfunction

    function automatic void load_window_length(input logic [WIN_W-1:0] w);
        // zero is dropped, state kept as is
        if (w == 0)
            return;
        win_len = (w > MAX_WINDOW) ? cnt_t'(MAX_WINDOW) : w;
        clear_history();
    endfunction

    function automatic vote_word_t tally_label(input logic [LABEL_W-1:0] lbl);
        vote_word_t   w;
        logic [3:0]   idx;
        logic [3:0]   oldest;
        logic [5:0]   slot;
        int           best;
        if (lbl < 1 || lbl > NUM_CLASSES)
        begin
            w.voted = '0;
            w.bad   = 1'b1;
            return w;
        end
        idx = 4'(lbl - 1);
        // full window: retire the oldest label first
        if (hist_fill >= win_len && hist_fill > 0)
        begin
            oldest = label_hist[hist_head];
            if (class_tally[oldest] > 0)
                class_tally[oldest] = class_tally[oldest] - 1'b1;
            hist_head = hist_head + 1'b1;
            hist_fill = hist_fill - 1'b1;
        end
        slot = hist_head + hist_fill[5:0];
        label_hist[slot] = idx;
        hist_fill = hist_fill + 1'b1;
        class_tally[idx] = class_tally[idx] + 1'b1;
        best = 0;
        for (int i = 1; i < NUM_CLASSES; i++)
            if (class_tally[i] > class_tally[best])
                best = i;
        w.voted = VOTE_W'(best + 1);
        w.bad   = 1'b0;
        return w;
    endfunction

    function automatic logic [LABEL_W-1:0] pick_label();
        int r;
        r = $urandom_range(99);
        if (r < 12)
            return LABEL_W'($urandom_range(255));
        if (r < 14)
            return '0;
        // a few hot classes make majorities and ties common
        if (r < 60)
            return LABEL_W'(hot_base + $urandom_range(3));
        return LABEL_W'($urandom_range(NUM_CLASSES, 1));
    endfunction

    function automatic logic [WIN_W-1:0] pick_window();
        case ($urandom_range(9))
            0: return 7'd1;
            1: return 7'(MAX_WINDOW);
            2: return 7'd2;
            3: return 7'd127;
            4: return 7'd0;
            5: return 7'(MAX_WINDOW + 1);
            default: return 7'($urandom_range(MAX_WINDOW, 1));
        endcase
    endfunction

    // tasks below start and end just after a falling edge
    task automatic send_label(input logic [LABEL_W-1:0] lbl);
        vote_word_t w;
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid    = 1'b1;
        class_label = lbl;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        w = tally_label(lbl);
        pending_votes.push_back(w);
        labels_sent++;
        if (w.bad)
            bad_sent++;
        @(negedge clk);
    endtask

    task automatic hold_until_drained();
        in_valid = 1'b0;
        while (pending_votes.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_window(input logic [WIN_W-1:0] w);
        hold_until_drained();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = w;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        load_window_length(w);
        window_writes++;
    endtask

    task automatic test_directed_labels();
        logic [LABEL_W-1:0] seq [25];
        seq = '{8'd1, 8'd16, 8'd16, 8'd1, 8'd0, 8'd17, 8'd255, 8'd128, 8'd64,
                8'd2, 8'd2, 8'd2, 8'd16, 8'd16, 8'd16, 8'd16,
                8'd7, 8'd7, 8'd7, 8'd7, 8'd7, 8'd9, 8'd9, 8'd9, 8'd9};
        // reset window of 16, ties, bad labels, then overflow of the window
        foreach (seq[i])
            send_label(seq[i]);
    endtask

    task automatic test_window_extremes();
        set_window(7'd1);
        repeat (6)
            send_label(pick_label());
        // zero write must leave window and history alone
        set_window(7'd0);
        repeat (4)
            send_label(pick_label());
        set_window(7'd127);
        hot_base = 5;
        repeat (80)
            send_label(pick_label());
        set_window(7'(MAX_WINDOW + 1));
        repeat (10)
            send_label(pick_label());
        set_window(7'd2);
        repeat (8)
            send_label(pick_label());
    endtask

    task automatic test_random_stream(input int src_pct, input int dst_pct,
                                      input int n_items);
        int sent;
        int chunk_len;
        src_idle_pct = src_pct;
        dst_idle_pct = dst_pct;
        sent = 0;
        while (sent < n_items)
        begin
            set_window(pick_window());
            hot_base  = $urandom_range(NUM_CLASSES - 3, 1);
            chunk_len = $urandom_range(90, 30);
            repeat (chunk_len)
            begin
                if ($urandom_range(39) == 0)
                    hold_until_drained();
                send_label(pick_label());
            end
            sent += chunk_len;
        end
    endtask

    always @(negedge clk)
        out_stall = ($urandom_range(99) < dst_idle_pct);

    always @(posedge clk)
    begin : vote_check
        vote_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_votes.size() == 0)
            begin
                $display("%0t: unexpected vote word, voted_class %0d bad_label %0b",
                         $time, voted_class, bad_label);
                errors++;
            end
            else
            begin
                want = pending_votes.pop_front();
                votes_checked++;
                if (voted_class !== want.voted)
                begin
                    $display("%0t: voted_class expected %0d actual %0d",
                             $time, want.voted, voted_class);
                    errors++;
                end
                if (bad_label !== want.bad)
                begin
                    $display("%0t: bad_label expected %0b actual %0b",
                             $time, want.bad, bad_label);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("sliding_window_majority_vote_core verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        class_label   = '0;
        out_stall     = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        src_idle_pct  = 9;
        dst_idle_pct  = 60;
        hot_base      = 1;
        errors        = 0;
        labels_sent   = 0;
        bad_sent      = 0;
        votes_checked = 0;
        window_writes = 0;
        quiet_cycles  = 0;
        win_len       = cnt_t'(WIN_RESET);
        clear_history();
        repeat (6)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_labels();
        test_window_extremes();
        test_random_stream(9, 60, 200);
        test_random_stream(60, 9, 200);
        test_random_stream(0, 0, 200);

        hold_until_drained();
        repeat (TAIL_CYCLES)
            @(negedge clk);
        $display("%0d labels sent, %0d out of range, %0d votes checked",
                 labels_sent, bad_sent, votes_checked);
        $display("%0d window length writes incl. zero and saturating values",
                 window_writes);
        if (errors == 0 && pending_votes.size() == 0)
            $display("sliding_window_majority_vote_core verification clean");
        else
            $display("sliding_window_majority_vote_core verification failed");
        $finish;
    end

endmodule
